[rtl/oadc_pkg.sv]
// Shared types, codes and constants for the obstacle-avoid drive controller.
`timescale 1ns / 1ps

package oadc_pkg;

  // Mode machine runs on every MODE_DIVIDER-th tick (range 1 to 4)
  localparam int unsigned MODE_DIVIDER = 2;
  localparam int unsigned TICK_W       = 2;

  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned REV_W   = 5;
  localparam int unsigned WORD_W  = 8;
  localparam int unsigned CIDX_W  = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PIVOT_LIMIT   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_UTURN_LIMIT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_REVERSE_LIMIT = 2'd2;

  localparam logic [LIMIT_W-1:0] PIVOT_LIMIT_RST   = 4'd7;
  localparam logic [LIMIT_W-1:0] UTURN_LIMIT_RST   = 4'd8;
  localparam logic [LIMIT_W-1:0] REVERSE_LIMIT_RST = 4'd8;

  // Motor port words
  localparam logic [WORD_W-1:0] MOTOR_STOP     = 8'h00;
  localparam logic [WORD_W-1:0] MOTOR_STRAIGHT = 8'h05;
  localparam logic [WORD_W-1:0] MOTOR_TURN_L   = 8'h01;
  localparam logic [WORD_W-1:0] MOTOR_TURN_R   = 8'h04;
  localparam logic [WORD_W-1:0] MOTOR_PIVOT_L  = 8'h09;
  localparam logic [WORD_W-1:0] MOTOR_PIVOT_R  = 8'h06;
  localparam logic [WORD_W-1:0] MOTOR_REVERSE  = 8'h0A;
  localparam logic [WORD_W-1:0] MOTOR_UTURN    = 8'h06;

  // Upper bound of the reverse counter (limit max plus one)
  localparam logic [REV_W-1:0] REV_COUNT_MAX = 5'd16;

  typedef enum logic [3:0] {
    MV_UNSTARTED = 4'd0,
    MV_INIT      = 4'd1,
    MV_WAIT      = 4'd2,
    MV_STRAIGHT  = 4'd3,
    MV_TL        = 4'd4,
    MV_TR        = 4'd5,
    MV_RL        = 4'd6,
    MV_RR        = 4'd7,
    MV_REVERSE   = 4'd8,
    MV_UT        = 4'd9
  } move_state_t;

  typedef enum logic [1:0] {
    MD_INIT    = 2'd0,
    MD_MANUAL  = 2'd1,
    MD_AUTO    = 2'd2,
    MD_RELEASE = 2'd3
  } mode_state_t;

  typedef enum logic [1:0] {
    FL_INIT    = 2'd0,
    FL_STANDBY = 2'd1,
    FL_FOLLOW  = 2'd2
  } follow_state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] pivot_limit;
    logic [LIMIT_W-1:0] uturn_limit;
    logic [LIMIT_W-1:0] reverse_limit;
  } cfg_t;

  // Movement machine result for one tick
  typedef struct packed {
    logic              first;  // machines not yet started
    logic              wr;     // movement writes the motor word
    logic [WORD_W-1:0] word;
  } move_out_t;

  // Mode / follow result for one tick
  typedef struct packed {
    logic auto_now;   // flag before this tick
    logic auto_next;  // flag after this tick
    logic follow_wr;  // remote byte goes to the motor word
  } mode_out_t;

endpackage

[rtl/oadc_move.sv]
// Movement state machine with pivot, U-turn and reverse counters.
`timescale 1ns / 1ps

module oadc_move (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               left_obstacle,
  input  logic               front_obstacle,
  input  logic               right_obstacle,
  input  logic               auto_now,
  input  oadc_pkg::cfg_t     cfg,
  output oadc_pkg::move_out_t mv
);

  oadc_pkg::move_state_t state, state_next;
  logic [oadc_pkg::LIMIT_W-1:0] left_pivot_count, left_pivot_count_next;
  logic [oadc_pkg::LIMIT_W-1:0] right_pivot_count, right_pivot_count_next;
  logic [oadc_pkg::LIMIT_W-1:0] uturn_count, uturn_count_next;
  logic [oadc_pkg::REV_W-1:0]   reverse_count, reverse_count_next;

  // Next state and counters
  always_comb begin
    state_next             = state;
    left_pivot_count_next  = left_pivot_count;
    right_pivot_count_next = right_pivot_count;
    uturn_count_next       = uturn_count;
    reverse_count_next     = reverse_count;
    unique case (state)
      oadc_pkg::MV_UNSTARTED: state_next = oadc_pkg::MV_INIT;
      oadc_pkg::MV_INIT:      state_next = oadc_pkg::MV_WAIT;
      oadc_pkg::MV_WAIT: begin
        state_next = auto_now ? oadc_pkg::MV_STRAIGHT : oadc_pkg::MV_WAIT;
      end
      oadc_pkg::MV_STRAIGHT: begin
        // leaving automatic wins, then all three sensors, then right, left, front
        priority if (!auto_now) state_next = oadc_pkg::MV_WAIT;
        else if (left_obstacle && front_obstacle && right_obstacle)
          state_next = oadc_pkg::MV_UT;
        else if (right_obstacle)
          state_next = front_obstacle ? oadc_pkg::MV_RL : oadc_pkg::MV_TL;
        else if (left_obstacle)
          state_next = front_obstacle ? oadc_pkg::MV_RR : oadc_pkg::MV_TR;
        else if (front_obstacle) state_next = oadc_pkg::MV_REVERSE;
        else state_next = oadc_pkg::MV_STRAIGHT;
      end
      oadc_pkg::MV_TL, oadc_pkg::MV_TR: state_next = oadc_pkg::MV_STRAIGHT;
      oadc_pkg::MV_RL: begin
        if (left_pivot_count >= cfg.pivot_limit) begin
          left_pivot_count_next = '0;
          state_next            = oadc_pkg::MV_RR;
        end else begin
          left_pivot_count_next = left_pivot_count + 4'd1;
          state_next            = oadc_pkg::MV_STRAIGHT;
        end
      end
      oadc_pkg::MV_RR: begin
        if (right_pivot_count >= cfg.pivot_limit) begin
          right_pivot_count_next = '0;
          state_next             = oadc_pkg::MV_RL;
        end else begin
          right_pivot_count_next = right_pivot_count + 4'd1;
          state_next             = oadc_pkg::MV_STRAIGHT;
        end
      end
      oadc_pkg::MV_UT: begin
        if (uturn_count >= cfg.uturn_limit) begin
          uturn_count_next = '0;
          state_next       = oadc_pkg::MV_STRAIGHT;
        end else begin
          uturn_count_next = uturn_count + 4'd1;
          state_next       = oadc_pkg::MV_UT;
        end
      end
      oadc_pkg::MV_REVERSE: begin
        if (reverse_count > {1'b0, cfg.reverse_limit}) begin
          reverse_count_next = '0;
          state_next         = oadc_pkg::MV_RR;
        end else begin
          reverse_count_next = reverse_count + 5'd1;
          state_next         = oadc_pkg::MV_REVERSE;
        end
      end
      default: state_next = oadc_pkg::MV_INIT;
    endcase
  end

  // Motor word for the state being entered
  always_comb begin
    mv.first = (state == oadc_pkg::MV_UNSTARTED);
    mv.wr    = 1'b1;
    mv.word  = oadc_pkg::MOTOR_STOP;
    unique case (state_next)
      oadc_pkg::MV_WAIT:     mv.word = oadc_pkg::MOTOR_STOP;
      oadc_pkg::MV_STRAIGHT: mv.word = oadc_pkg::MOTOR_STRAIGHT;
      oadc_pkg::MV_TL:       mv.word = oadc_pkg::MOTOR_TURN_L;
      oadc_pkg::MV_TR:       mv.word = oadc_pkg::MOTOR_TURN_R;
      oadc_pkg::MV_RL:       mv.word = oadc_pkg::MOTOR_PIVOT_L;
      oadc_pkg::MV_RR:       mv.word = oadc_pkg::MOTOR_PIVOT_R;
      oadc_pkg::MV_REVERSE:  mv.word = oadc_pkg::MOTOR_REVERSE;
      oadc_pkg::MV_UT:       mv.word = oadc_pkg::MOTOR_UTURN;
      default:               mv.wr   = 1'b0;
    endcase
  end

  // State update, one step per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= oadc_pkg::MV_UNSTARTED;
      left_pivot_count  <= '0;
      right_pivot_count <= '0;
      uturn_count       <= '0;
      reverse_count     <= '0;
    end else if (advance) begin
      state             <= state_next;
      left_pivot_count  <= left_pivot_count_next;
      right_pivot_count <= right_pivot_count_next;
      uturn_count       <= uturn_count_next;
      reverse_count     <= reverse_count_next;
    end
  end

  // reverse counter never runs past the largest limit plus one
  a_rev_bound: assert property (@(posedge clk) disable iff (rst)
    reverse_count <= oadc_pkg::REV_COUNT_MAX)
    else $error("reverse counter out of range");

  // counters only move on an accepted word
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(uturn_count) && $stable(reverse_count))
    else $error("counter changed without a word");

endmodule

[rtl/oadc_mode.sv]
// Mode toggle debounce machine, tick divider and remote-follow machine.
`timescale 1ns / 1ps

module oadc_mode (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                first,
  input  logic                mode_button,
  output oadc_pkg::mode_out_t md
);

  oadc_pkg::mode_state_t   mode_state, mode_state_next;
  oadc_pkg::follow_state_t follow_state, follow_state_next;
  logic                    auto_flag, auto_flag_next;
  logic [oadc_pkg::TICK_W-1:0] tick_phase, tick_phase_next;
  logic [oadc_pkg::TICK_W:0]   tick_sum;

  // Tick divider
  always_comb begin
    tick_sum = {1'b0, tick_phase} + 3'd1;
    if (tick_sum >= 3'(oadc_pkg::MODE_DIVIDER)) tick_phase_next = '0;
    else tick_phase_next = tick_sum[oadc_pkg::TICK_W-1:0];
  end

  // Mode machine next state, only on divider ticks
  always_comb begin
    mode_state_next = mode_state;
    if (tick_phase == '0) begin
      if (first) begin
        mode_state_next = oadc_pkg::MD_INIT;
      end else begin
        unique case (mode_state)
          oadc_pkg::MD_INIT: mode_state_next = oadc_pkg::MD_MANUAL;
          oadc_pkg::MD_MANUAL: begin
            mode_state_next = mode_button ? oadc_pkg::MD_RELEASE : oadc_pkg::MD_MANUAL;
          end
          oadc_pkg::MD_AUTO: begin
            mode_state_next = mode_button ? oadc_pkg::MD_RELEASE : oadc_pkg::MD_AUTO;
          end
          default: begin
            // toggle on release
            if (!mode_button)
              mode_state_next = auto_flag ? oadc_pkg::MD_MANUAL : oadc_pkg::MD_AUTO;
          end
        endcase
      end
    end
  end

  // Mode flag follows the entered mode state
  always_comb begin
    auto_flag_next = auto_flag;
    if (tick_phase == '0) begin
      unique case (mode_state_next)
        oadc_pkg::MD_INIT, oadc_pkg::MD_MANUAL: auto_flag_next = 1'b0;
        oadc_pkg::MD_AUTO:                      auto_flag_next = 1'b1;
        default:                                auto_flag_next = auto_flag;
      endcase
    end
  end

  // Follow machine next state, uses the updated flag
  always_comb begin
    follow_state_next = follow_state;
    if (first) begin
      follow_state_next = oadc_pkg::FL_INIT;
    end else begin
      unique case (follow_state)
        oadc_pkg::FL_INIT: follow_state_next = oadc_pkg::FL_STANDBY;
        oadc_pkg::FL_STANDBY, oadc_pkg::FL_FOLLOW: begin
          follow_state_next = auto_flag_next ? oadc_pkg::FL_STANDBY : oadc_pkg::FL_FOLLOW;
        end
        default: follow_state_next = oadc_pkg::FL_INIT;
      endcase
    end
  end

  // Outputs
  always_comb begin
    md.auto_now  = auto_flag;
    md.auto_next = auto_flag_next;
    md.follow_wr = (follow_state_next == oadc_pkg::FL_FOLLOW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state   <= oadc_pkg::MD_INIT;
      follow_state <= oadc_pkg::FL_INIT;
      auto_flag    <= 1'b0;
      tick_phase   <= '0;
    end else if (advance) begin
      mode_state   <= mode_state_next;
      follow_state <= follow_state_next;
      auto_flag    <= auto_flag_next;
      tick_phase   <= tick_phase_next;
    end
  end

  // remote byte only drives the motor in manual mode
  a_follow_manual: assert property (@(posedge clk) disable iff (rst)
    md.follow_wr |-> !md.auto_next)
    else $error("remote follow while automatic");

  // flag only changes on a divider tick
  a_flag_tick: assert property (@(posedge clk) disable iff (rst)
    (tick_phase != '0) |-> (auto_flag_next == auto_flag))
    else $error("mode flag changed off a divider tick");

endmodule

[rtl/obstacle_avoid_drive_controller_top.sv]
// Top level of the obstacle-avoid drive controller: handshake, registers, motor word.
`timescale 1ns / 1ps

// One input word is one scheduler tick carrying the three obstacle sensors, the mode
// button and the latest remote byte; each tick yields exactly one result word with the
// held 8-bit motor word and the automatic-mode flag as they stand after that tick.
// The input stalls only while a finished result is waiting and the output is stalled;
// otherwise a tick is taken every clock cycle. Its work is one pass of next-state
// logic into the state registers, and the motor word and mode flag registers double as
// the output register. Limit registers are to be written by the user through the cfg
// port only while no tick is in flight; the block does not enforce this.

module obstacle_avoid_drive_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           left_obstacle,
  input  logic                           front_obstacle,
  input  logic                           right_obstacle,
  input  logic                           mode_button,
  input  logic [oadc_pkg::WORD_W-1:0]    remote_byte,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [oadc_pkg::WORD_W-1:0]    motor_drive,
  output logic                           auto_active,
  // configuration
  input  logic                           cfg_we,
  input  logic [oadc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [oadc_pkg::LIMIT_W-1:0]   cfg_data
);

  oadc_pkg::cfg_t      cfg;
  oadc_pkg::move_out_t mv;
  oadc_pkg::mode_out_t md;
  logic                          accept;
  logic [oadc_pkg::WORD_W-1:0]   motor_latch, motor_latch_next;

  // Handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  oadc_move u_move (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .left_obstacle  (left_obstacle),
    .front_obstacle (front_obstacle),
    .right_obstacle (right_obstacle),
    .auto_now       (md.auto_now),
    .cfg            (cfg),
    .mv             (mv)
  );

  oadc_mode u_mode (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .first       (mv.first),
    .mode_button (mode_button),
    .md          (md)
  );

  // Motor word: remote follow overrides the movement machine
  always_comb begin
    priority if (md.follow_wr) motor_latch_next = remote_byte;
    else if (mv.wr)            motor_latch_next = mv.word;
    else                       motor_latch_next = motor_latch;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pivot_limit   <= oadc_pkg::PIVOT_LIMIT_RST;
      cfg.uturn_limit   <= oadc_pkg::UTURN_LIMIT_RST;
      cfg.reverse_limit <= oadc_pkg::REVERSE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        oadc_pkg::CFG_PIVOT_LIMIT:   cfg.pivot_limit   <= cfg_data;
        oadc_pkg::CFG_UTURN_LIMIT:   cfg.uturn_limit   <= cfg_data;
        oadc_pkg::CFG_REVERSE_LIMIT: cfg.reverse_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Held motor word and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_latch <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) motor_latch <= motor_latch_next;
      if (accept) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign motor_drive = motor_latch;
  assign auto_active = md.auto_now;

  // a word is produced for every accepted tick
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick gave no result");

  // held motor word only moves with an accepted tick
  a_motor_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(motor_drive) && $stable(auto_active))
    else $error("result changed without a tick");

endmodule

[sim/tb_obstacle_avoid_drive_controller_top.sv]
// Self-checking testbench for the obstacle-avoid drive controller top level.
`timescale 1ns / 1ps

module tb_obstacle_avoid_drive_controller_top;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned IDLE_PCT      = 27;
  localparam int unsigned PHASE_TICKS   = 165;
  localparam int unsigned DRAIN_CYCLES  = 4;
  // index past the last register: writes there must be ignored
  localparam logic [oadc_pkg::CIDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic                        left;
    logic                        front;
    logic                        right;
    logic                        button;
    logic [oadc_pkg::WORD_W-1:0] remote;
  } sensor_tick_t;

  typedef struct {
    logic [oadc_pkg::WORD_W-1:0] motor;
    logic                        auto_on;
  } drive_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         left_obstacle = 1'b0;
  logic                         front_obstacle = 1'b0;
  logic                         right_obstacle = 1'b0;
  logic                         mode_button = 1'b0;
  logic [oadc_pkg::WORD_W-1:0]  remote_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [oadc_pkg::WORD_W-1:0]  motor_drive;
  logic                         auto_active;
  logic                         cfg_we = 1'b0;
  logic [oadc_pkg::CIDX_W-1:0]  cfg_index = '0;
  logic [oadc_pkg::LIMIT_W-1:0] cfg_data = '0;

  sensor_tick_t ticks_pending[$];
  drive_word_t  drive_words_due[$];
  logic         in_taken = 1'b0;
  bit           send_steady = 1'b0;
  bit           recv_steady = 1'b0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // Predictor state
  oadc_pkg::cfg_t               lim;
  oadc_pkg::move_state_t        mv_st;
  oadc_pkg::mode_state_t        md_st;
  oadc_pkg::follow_state_t      fl_st;
  logic                         auto_on;
  logic [oadc_pkg::LIMIT_W-1:0] lpc, rpc, utc;
  logic [oadc_pkg::REV_W-1:0]   revc;
  logic [oadc_pkg::WORD_W-1:0]  motor;
  int unsigned                  tick_ph;

  obstacle_avoid_drive_controller_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_obstacle  (left_obstacle),
    .front_obstacle (front_obstacle),
    .right_obstacle (right_obstacle),
    .mode_button    (mode_button),
    .remote_byte    (remote_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .motor_drive    (motor_drive),
    .auto_active    (auto_active),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic clear_controller();
    lim     = '{pivot_limit: oadc_pkg::PIVOT_LIMIT_RST,
                uturn_limit: oadc_pkg::UTURN_LIMIT_RST,
                reverse_limit: oadc_pkg::REVERSE_LIMIT_RST};
    mv_st   = oadc_pkg::MV_UNSTARTED;
    md_st   = oadc_pkg::MD_INIT;
    fl_st   = oadc_pkg::FL_INIT;
    auto_on = 1'b0;
    lpc     = '0;
    rpc     = '0;
    utc     = '0;
    revc    = '0;
    motor   = oadc_pkg::MOTOR_STOP;
    tick_ph = 0;
  endtask

  // One scheduler tick: movement, then mode (divided), then remote follow
  task automatic advance_controller(input sensor_tick_t t, output drive_word_t res);
    logic                  first_tick;
    oadc_pkg::move_state_t nxt;
    first_tick = (mv_st == oadc_pkg::MV_UNSTARTED);
    nxt = mv_st;
    case (mv_st)
      oadc_pkg::MV_UNSTARTED: nxt = oadc_pkg::MV_INIT;
      oadc_pkg::MV_INIT:      nxt = oadc_pkg::MV_WAIT;
      oadc_pkg::MV_WAIT:      nxt = auto_on ? oadc_pkg::MV_STRAIGHT : oadc_pkg::MV_WAIT;
      oadc_pkg::MV_STRAIGHT: begin
        if (!auto_on) nxt = oadc_pkg::MV_WAIT;
        else if (t.left && t.front && t.right) nxt = oadc_pkg::MV_UT;
        else if (t.right) nxt = t.front ? oadc_pkg::MV_RL : oadc_pkg::MV_TL;
        else if (t.left) nxt = t.front ? oadc_pkg::MV_RR : oadc_pkg::MV_TR;
        else if (t.front) nxt = oadc_pkg::MV_REVERSE;
        else nxt = oadc_pkg::MV_STRAIGHT;
      end
      oadc_pkg::MV_TL, oadc_pkg::MV_TR: nxt = oadc_pkg::MV_STRAIGHT;
      oadc_pkg::MV_RL: begin
        if (lpc >= lim.pivot_limit) begin
          lpc = '0;
          nxt = oadc_pkg::MV_RR;
        end else begin
          lpc = lpc + 1'b1;
          nxt = oadc_pkg::MV_STRAIGHT;
        end
      end
      oadc_pkg::MV_RR: begin
        if (rpc >= lim.pivot_limit) begin
          rpc = '0;
          nxt = oadc_pkg::MV_RL;
        end else begin
          rpc = rpc + 1'b1;
          nxt = oadc_pkg::MV_STRAIGHT;
        end
      end
      oadc_pkg::MV_UT: begin
        if (utc >= lim.uturn_limit) begin
          utc = '0;
          nxt = oadc_pkg::MV_STRAIGHT;
        end else begin
          utc = utc + 1'b1;
          nxt = oadc_pkg::MV_UT;
        end
      end
      oadc_pkg::MV_REVERSE: begin
        if (revc > {1'b0, lim.reverse_limit}) begin
          revc = '0;
          nxt = oadc_pkg::MV_RR;
        end else begin
          revc = revc + 1'b1;
          nxt = oadc_pkg::MV_REVERSE;
        end
      end
      default: nxt = oadc_pkg::MV_INIT;
    endcase
    mv_st = nxt;
    case (nxt)
      oadc_pkg::MV_WAIT:     motor = oadc_pkg::MOTOR_STOP;
      oadc_pkg::MV_STRAIGHT: motor = oadc_pkg::MOTOR_STRAIGHT;
      oadc_pkg::MV_TL:       motor = oadc_pkg::MOTOR_TURN_L;
      oadc_pkg::MV_TR:       motor = oadc_pkg::MOTOR_TURN_R;
      oadc_pkg::MV_RL:       motor = oadc_pkg::MOTOR_PIVOT_L;
      oadc_pkg::MV_RR:       motor = oadc_pkg::MOTOR_PIVOT_R;
      oadc_pkg::MV_REVERSE:  motor = oadc_pkg::MOTOR_REVERSE;
      oadc_pkg::MV_UT:       motor = oadc_pkg::MOTOR_UTURN;
      default: ;
    endcase

    // mode debounce, only on divided ticks
    if (tick_ph == 0) begin
      if (first_tick) md_st = oadc_pkg::MD_INIT;
      else begin
        case (md_st)
          oadc_pkg::MD_INIT:   md_st = oadc_pkg::MD_MANUAL;
          oadc_pkg::MD_MANUAL: md_st = t.button ? oadc_pkg::MD_RELEASE : oadc_pkg::MD_MANUAL;
          oadc_pkg::MD_AUTO:   md_st = t.button ? oadc_pkg::MD_RELEASE : oadc_pkg::MD_AUTO;
          default: begin
            if (!t.button) md_st = auto_on ? oadc_pkg::MD_MANUAL : oadc_pkg::MD_AUTO;
          end
        endcase
      end
      if (md_st == oadc_pkg::MD_INIT || md_st == oadc_pkg::MD_MANUAL) auto_on = 1'b0;
      else if (md_st == oadc_pkg::MD_AUTO) auto_on = 1'b1;
    end
    tick_ph = (tick_ph + 1 >= oadc_pkg::MODE_DIVIDER) ? 0 : tick_ph + 1;

    // remote follow uses the fresh mode flag
    if (first_tick) fl_st = oadc_pkg::FL_INIT;
    else begin
      case (fl_st)
        oadc_pkg::FL_INIT:    fl_st = oadc_pkg::FL_STANDBY;
        oadc_pkg::FL_STANDBY: fl_st = auto_on ? oadc_pkg::FL_STANDBY : oadc_pkg::FL_FOLLOW;
        oadc_pkg::FL_FOLLOW:  fl_st = auto_on ? oadc_pkg::FL_STANDBY : oadc_pkg::FL_FOLLOW;
        default:              fl_st = oadc_pkg::FL_INIT;
      endcase
    end
    if (fl_st == oadc_pkg::FL_FOLLOW) motor = t.remote;

    res.motor   = motor;
    res.auto_on = auto_on;
  endtask

  task automatic queue_tick(input logic l, f, r, b,
                            input logic [oadc_pkg::WORD_W-1:0] remote);
    sensor_tick_t t;
    t.left   = l;
    t.front  = f;
    t.right  = r;
    t.button = b;
    t.remote = remote;
    ticks_pending.push_back(t);
  endtask

  task automatic queue_random_tick(input int unsigned sensor_pct, input logic b);
    queue_tick($urandom_range(0, 99) < sensor_pct, $urandom_range(0, 99) < sensor_pct,
               $urandom_range(0, 99) < sensor_pct, b, 8'($urandom_range(0, 255)));
  endtask

  // Mostly mode toggles followed by runs of sensor traffic; some button noise
  task automatic queue_drive_phase(input int unsigned n_ticks);
    int unsigned sensor_pct;
    int unsigned run_len;
    while (ticks_pending.size() < n_ticks) begin
      case ($urandom_range(0, 3))
        0: sensor_pct = 5;
        1: sensor_pct = 25;
        2: sensor_pct = 50;
        default: sensor_pct = 80;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(4, 12)) queue_random_tick(sensor_pct, $urandom_range(0, 99) < 40);
      end else begin
        // hold the press across two ticks so one mode tick sees it
        repeat (2) queue_random_tick(sensor_pct, 1'b1);
        run_len = $urandom_range(8, 60);
        repeat (run_len) queue_random_tick(sensor_pct, 1'b0);
      end
    end
  endtask

  task automatic wait_all_drained();
    while (ticks_pending.size() != 0 || in_valid || drive_words_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic apply_limits(input logic [oadc_pkg::LIMIT_W-1:0] piv, ut, rev);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= oadc_pkg::CFG_PIVOT_LIMIT;
    cfg_data  <= piv;
    @(negedge clk);
    cfg_index <= oadc_pkg::CFG_UTURN_LIMIT;
    cfg_data  <= ut;
    @(negedge clk);
    cfg_index <= oadc_pkg::CFG_REVERSE_LIMIT;
    cfg_data  <= rev;
    @(negedge clk);
    cfg_index <= CFG_SPARE_IDX;
    cfg_data  <= ~piv;
    @(negedge clk);
    cfg_we    <= 1'b0;
    lim = '{pivot_limit: piv, uturn_limit: ut, reverse_limit: rev};
  endtask

  // Driver: new word at the falling edge, held while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: keep the word
    end else if (ticks_pending.size() != 0 &&
                 (send_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
      sensor_tick_t t;
      t = ticks_pending.pop_front();
      in_valid       <= 1'b1;
      left_obstacle  <= t.left;
      front_obstacle <= t.front;
      right_obstacle <= t.right;
      mode_button    <= t.button;
      remote_byte    <= t.remote;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= !rst && !recv_steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor: check the result word, then predict for the accepted tick
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (drive_words_due.size() == 0) begin
          $display("%0t: unexpected result word motor_drive %02h auto_active %0b",
                   $time, motor_drive, auto_active);
          mismatch_count++;
        end else begin
          drive_word_t exp_w;
          exp_w = drive_words_due.pop_front();
          if (motor_drive !== exp_w.motor) begin
            $display("%0t: motor_drive expected %02h actual %02h",
                     $time, exp_w.motor, motor_drive);
            mismatch_count++;
          end
          if (auto_active !== exp_w.auto_on) begin
            $display("%0t: auto_active expected %0b actual %0b",
                     $time, exp_w.auto_on, auto_active);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        sensor_tick_t t;
        drive_word_t  res;
        t.left   = left_obstacle;
        t.front  = front_obstacle;
        t.right  = right_obstacle;
        t.button = mode_button;
        t.remote = remote_byte;
        advance_controller(t, res);
        drive_words_due.push_back(res);
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus sequence
  initial begin
    clear_controller();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first tick, remote extremes, entering auto, each sensor pattern
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'hA5);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'h5A);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h11);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h22);
    queue_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h33);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h44);
    queue_tick(1'b0, 1'b1, 1'b1, 1'b0, 8'h55);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h66);
    queue_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h77);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h88);
    queue_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'h99);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'hAA);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'hBB);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'hCC);
    queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'hDD);
    // leave auto while the sensors are all set
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'hEE);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'h0F);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'hF0);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'h3C);
    wait_all_drained();

    // Random phases under several limit settings; the sender holds off at each boundary
    for (int ph = 0; ph < 6; ph++) begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      case (ph)
        0: apply_limits(4'd0, 4'd0, 4'd0);
        1: apply_limits(4'd15, 4'd15, 4'd15);
        2: apply_limits(4'd1, 4'd15, 4'd0);
        3: apply_limits(4'd15, 4'd0, 4'd15);
        default: apply_limits(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)));
      endcase
      send_steady = (ph == 2);
      recv_steady = (ph == 2);
      queue_drive_phase(PHASE_TICKS);
      wait_all_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && drive_words_due.size() == 0 && ticks_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[obstacle_avoid_drive_controller_top.f]
rtl/oadc_pkg.sv
rtl/oadc_move.sv
rtl/oadc_mode.sv
rtl/obstacle_avoid_drive_controller_top.sv
sim/tb_obstacle_avoid_drive_controller_top.sv
